@@ hw/rtl/rbs_pkg.sv @@
// shared constants and types for the ray / box slab test
package rbs_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned AXES = 3;

  // dividend magnitude: 33-bit difference shifted by the fraction width
  localparam int unsigned NUM_W = COORD_W + 1 + FRAC_W;
  // quotient bits developed by the divider, one above the signed range
  localparam int unsigned QUO_W = COORD_W + 1;
  localparam int unsigned DIV_STEPS = 3;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;
  // divider stages plus the saturation register
  localparam int unsigned DIV_LAT = DIV_STAGES + 1;

  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_MAX_DISTANCE = 3'd0;
  localparam logic [COORD_W-1:0] MAX_DISTANCE_RESET = 32'h7fff_ffff;

  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7fff_ffff;

  typedef logic signed [COORD_W-1:0] coord_t;

  // per-request flags that travel beside the dividers
  typedef struct packed {
    logic valid;
    logic miss;
    logic [AXES-1:0] zero;
  } side_t;

endpackage

@@ hw/rtl/rbs_div.sv @@
// pipelined unsigned restoring divider with signed saturation to q16.16
module rbs_div (
  input  logic clk,
  input  logic en,
  input  logic [rbs_pkg::NUM_W-1:0] num_mag,
  input  logic [rbs_pkg::COORD_W-1:0] den_mag,
  input  logic neg,
  output rbs_pkg::coord_t quot
);

  localparam int unsigned QW = rbs_pkg::QUO_W;
  localparam int unsigned CW = rbs_pkg::COORD_W;
  localparam int unsigned NS = rbs_pkg::DIV_STAGES;
  localparam int unsigned HI_W = rbs_pkg::NUM_W - QW;

  logic [QW-1:0] rem_r [1:NS];
  logic [QW-1:0] nb_r [1:NS];
  logic [QW-1:0] quo_r [1:NS];
  logic [CW-1:0] den_r [1:NS];
  logic neg_r [1:NS];
  logic big_r [1:NS];

  logic [QW-1:0] mag;
  logic over;

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_stage
      logic [QW-1:0] rem_in, nb_in, quo_in;
      logic [CW-1:0] den_in;
      logic neg_in, big_in;
      logic [QW-1:0] rem_o, nb_o, quo_o;

      if (s == 0) begin : g_first
        assign rem_in = QW'(num_mag[rbs_pkg::NUM_W-1:QW]);
        assign nb_in = num_mag[QW-1:0];
        assign quo_in = '0;
        assign den_in = den_mag;
        assign neg_in = neg;
        // quotient would need more than the developed bits
        assign big_in = {{(CW-HI_W){1'b0}}, num_mag[rbs_pkg::NUM_W-1:QW]} >= den_mag;
      end else begin : g_rest
        assign rem_in = rem_r[s];
        assign nb_in = nb_r[s];
        assign quo_in = quo_r[s];
        assign den_in = den_r[s];
        assign neg_in = neg_r[s];
        assign big_in = big_r[s];
      end

      always_comb begin
        logic [QW-1:0] r;
        logic ge;
        rem_o = rem_in;
        nb_o = nb_in;
        quo_o = quo_in;
        for (int k = 0; k < rbs_pkg::DIV_STEPS; k++) begin
          r = {rem_o[QW-2:0], nb_o[QW-1]};
          ge = r >= {1'b0, den_in};
          rem_o = ge ? r - {1'b0, den_in} : r;
          nb_o = {nb_o[QW-2:0], 1'b0};
          quo_o = {quo_o[QW-2:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= rem_o;
          nb_r[s+1] <= nb_o;
          quo_r[s+1] <= quo_o;
          den_r[s+1] <= den_in;
          neg_r[s+1] <= neg_in;
          big_r[s+1] <= big_in;
        end
      end
    end
  endgenerate

  assign mag = quo_r[NS];

  always_comb begin
    if (neg_r[NS]) begin
      over = big_r[NS] || mag[QW-1] || (mag[QW-2] && (|mag[QW-3:0]));
    end else begin
      over = big_r[NS] || mag[QW-1] || mag[QW-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (over) begin
        quot <= neg_r[NS] ? ~rbs_pkg::Q_MAX : rbs_pkg::Q_MAX;
      end else if (neg_r[NS]) begin
        quot <= -$signed(mag[CW-1:0]);
      end else begin
        quot <= $signed(mag[CW-1:0]);
      end
    end
  end

endmodule

@@ hw/rtl/ray_box_slab_test.sv @@
// top level of the ray / box slab test
// Takes one ray/box request per cycle unless stalled and returns one hit bit per
// request, in order. The front register loads at the accepting edge; then 11
// divider stages of 3 quotient bits each, saturation, sort and final interval
// compare follow. Six pipelined restoring dividers turn slab offsets into
// distances. A stalled output holds the whole pipeline.
module ray_box_slab_test (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [rbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_min_z,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic signed [31:0] box_max_z,
  output logic out_valid,
  input  logic out_stall,
  output logic hit
);

  localparam int unsigned AX = rbs_pkg::AXES;
  localparam int unsigned CW = rbs_pkg::COORD_W;
  localparam int unsigned LAT = rbs_pkg::DIV_LAT;

  rbs_pkg::coord_t max_distance;
  rbs_pkg::coord_t org [AX];
  rbs_pkg::coord_t dir [AX];
  rbs_pkg::coord_t lo [AX];
  rbs_pkg::coord_t hi [AX];

  logic adv;

  // front stage registers
  rbs_pkg::side_t side_a;
  logic [rbs_pkg::NUM_W-1:0] nlo_a [AX];
  logic [rbs_pkg::NUM_W-1:0] nhi_a [AX];
  logic neglo_a [AX];
  logic neghi_a [AX];
  logic [CW-1:0] dmag_a [AX];
  rbs_pkg::side_t side_next;

  rbs_pkg::side_t side_d [1:LAT];
  rbs_pkg::coord_t tlo_q [AX];
  rbs_pkg::coord_t thi_q [AX];

  // sort stage
  rbs_pkg::side_t side_b;
  rbs_pkg::coord_t tmin_b [AX];
  rbs_pkg::coord_t tmax_b [AX];

  rbs_pkg::coord_t enter, leave, e01, l01;

  assign org = '{origin_x, origin_y, origin_z};
  assign dir = '{dir_x, dir_y, dir_z};
  assign lo = '{box_min_x, box_min_y, box_min_z};
  assign hi = '{box_max_x, box_max_y, box_max_z};

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == rbs_pkg::REG_MAX_DISTANCE) ? max_distance : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= rbs_pkg::MAX_DISTANCE_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == rbs_pkg::REG_MAX_DISTANCE) begin
      max_distance <= pwdata;
    end
  end

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    side_next.valid = in_valid;
    side_next.miss = max_distance <= 0;
    for (int a = 0; a < AX; a++) begin
      side_next.zero[a] = dir[a] == 0;
      if (lo[a] > hi[a]) side_next.miss = 1'b1;
      if (dir[a] == 0 && (org[a] < lo[a] || org[a] > hi[a])) side_next.miss = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CW:0] dl, dh;
    if (rst) begin
      side_a.valid <= 1'b0;
    end else if (adv) begin
      side_a.valid <= side_next.valid;
    end
    if (adv) begin
      side_a.miss <= side_next.miss;
      side_a.zero <= side_next.zero;
      for (int a = 0; a < AX; a++) begin
        dl = $signed({lo[a][CW-1], lo[a]}) - $signed({org[a][CW-1], org[a]});
        dh = $signed({hi[a][CW-1], hi[a]}) - $signed({org[a][CW-1], org[a]});
        nlo_a[a] <= {(dl[CW] ? -dl : dl), {rbs_pkg::FRAC_W{1'b0}}};
        nhi_a[a] <= {(dh[CW] ? -dh : dh), {rbs_pkg::FRAC_W{1'b0}}};
        neglo_a[a] <= dl[CW] ^ dir[a][CW-1];
        neghi_a[a] <= dh[CW] ^ dir[a][CW-1];
        dmag_a[a] <= dir[a][CW-1] ? -dir[a] : dir[a];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < AX; g++) begin : g_axis
      rbs_div u_div_lo (
        .clk(clk), .en(adv), .num_mag(nlo_a[g]), .den_mag(dmag_a[g]),
        .neg(neglo_a[g]), .quot(tlo_q[g])
      );
      rbs_div u_div_hi (
        .clk(clk), .en(adv), .num_mag(nhi_a[g]), .den_mag(dmag_a[g]),
        .neg(neghi_a[g]), .quot(thi_q[g])
      );
    end
  endgenerate

  // side flags ride alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LAT; i++) side_d[i] <= '0;
    end else if (adv) begin
      side_d[1] <= side_a;
      for (int i = 2; i <= LAT; i++) side_d[i] <= side_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_b <= '0;
    end else if (adv) begin
      side_b <= side_d[LAT];
    end
  end

  // order each pair; a zero-direction axis does not tighten the interval
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AX; a++) begin
        if (side_d[LAT].zero[a]) begin
          tmin_b[a] <= '0;
          tmax_b[a] <= rbs_pkg::Q_MAX;
        end else if (tlo_q[a] > thi_q[a]) begin
          tmin_b[a] <= thi_q[a];
          tmax_b[a] <= tlo_q[a];
        end else begin
          tmin_b[a] <= tlo_q[a];
          tmax_b[a] <= thi_q[a];
        end
      end
    end
  end

  always_comb begin
    e01 = (tmin_b[0] > tmin_b[1]) ? tmin_b[0] : tmin_b[1];
    enter = (tmin_b[2] > e01) ? tmin_b[2] : e01;
    if (enter < 0) enter = '0;
    l01 = (tmax_b[0] < tmax_b[1]) ? tmax_b[0] : tmax_b[1];
    leave = (tmax_b[2] < l01) ? tmax_b[2] : l01;
    if (max_distance < leave) leave = max_distance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= side_b.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= !side_b.miss && (enter <= leave);
    end
  end

endmodule
